[hdl/lr_pkg.sv]
// Types and constants shared by the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

	localparam int MAX_DIM    = 64;
	localparam int COORD_BITS = 10;
	localparam int DIM_BITS   = 7;
	localparam int PIX_BITS   = 6;
	localparam int COLOR_BITS = 24;
	localparam int ADX_BITS   = COORD_BITS + 1;
	localparam int NADY_BITS  = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int TWICE_BITS = ERR_BITS + 1;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_DIM);
	localparam logic [DIM_BITS-1:0] DIM_MAX   = DIM_BITS'(MAX_DIM);

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_LAST
	} lr_state_t;

endpackage

[hdl/line_rasterizer.sv]
// Line rasterizer top level: Bresenham walker with screen clipping.
`timescale 1ns / 1ps

// Takes one line command at a time and walks its integer Bresenham line, both
// endpoints included, one point per clock cycle unless the output side stalls,
// through a single error adder and compare unit. Points inside the screen become
// pixel requests; the final request of a command carries last_pixel, and a
// command with no visible point gives one request with pixel_valid low. A
// command passes through accept, one walk step per point and the issue of the
// final request, held up whenever the output side stalls; in_ready stays low
// from the cycle after accept until the block is idle again. Screen sizes above
// 64 are treated as 64; the user must see that they are written only while the
// block is idle, which the block itself does not enforce.
module line_rasterizer
	import lr_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [0:0]                   cfg_index,
	input  logic [DIM_BITS-1:0]          cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0]        line_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [PIX_BITS-1:0]          pixel_x,
	output logic [PIX_BITS-1:0]          pixel_y,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         pixel_valid,
	output logic                         last_pixel
);

	lr_state_t state_q, state_d;

	logic [DIM_BITS-1:0]          screen_width_q, screen_height_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic signed [ERR_BITS-1:0]   step_error_q;
	logic [ADX_BITS-1:0]          abs_dx_q;
	logic signed [NADY_BITS-1:0]  neg_abs_dy_q;
	logic                         x_dec_q, y_dec_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         held_valid_q;
	logic [PIX_BITS-1:0]          held_x_q, held_y_q;

	logic                         out_valid_q;
	logic [PIX_BITS-1:0]          pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0]        pixel_color_q;
	logic                         pixel_valid_q, last_pixel_q;

	logic [DIM_BITS-1:0]          w_sat, h_sat;
	logic                         visible, out_free;
	logic signed [TWICE_BITS-1:0] twice, adx_ext, nady_ext;
	logic                         x_cond, y_cond, done;
	logic signed [ERR_BITS-1:0]   err_next;
	logic                         accept, step_go, load_mid, load_final;

	logic signed [ADX_BITS-1:0]   dx_full, dy_full;
	logic [ADX_BITS-1:0]          init_adx;
	logic signed [NADY_BITS-1:0]  init_nady;
	logic signed [ERR_BITS-1:0]   init_err;

	assign w_sat = (screen_width_q > DIM_MAX) ? DIM_MAX : screen_width_q;
	assign h_sat = (screen_height_q > DIM_MAX) ? DIM_MAX : screen_height_q;

	assign visible = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1]
		&& (ADX_BITS'(unsigned'(cur_x_q)) < ADX_BITS'(w_sat))
		&& (ADX_BITS'(unsigned'(cur_y_q)) < ADX_BITS'(h_sat));

	assign out_free = !out_valid_q || out_ready;

	assign twice    = {step_error_q, 1'b0};
	assign adx_ext  = signed'(TWICE_BITS'(abs_dx_q));
	assign nady_ext = TWICE_BITS'(neg_abs_dy_q);
	assign x_cond   = twice >= nady_ext;
	assign y_cond   = twice <= adx_ext;
	assign done     = (x_cond && (cur_x_q == target_x_q))
		|| (y_cond && (cur_y_q == target_y_q));
	assign err_next = step_error_q
		+ (x_cond ? ERR_BITS'(neg_abs_dy_q) : ERR_BITS'(0))
		+ (y_cond ? signed'(ERR_BITS'(abs_dx_q)) : ERR_BITS'(0));

	assign dx_full   = ADX_BITS'(end_x) - ADX_BITS'(start_x);
	assign dy_full   = ADX_BITS'(end_y) - ADX_BITS'(start_y);
	assign init_adx  = dx_full[ADX_BITS-1] ? unsigned'(-dx_full) : unsigned'(dx_full);
	assign init_nady = dy_full[ADX_BITS-1] ? NADY_BITS'(dy_full)
		: -NADY_BITS'(dy_full);
	assign init_err  = signed'(ERR_BITS'(init_adx)) + ERR_BITS'(init_nady);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		step_go    = 1'b0;
		load_mid   = 1'b0;
		load_final = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				accept = in_valid;
				if (in_valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				step_go  = !visible || !held_valid_q || out_free;
				load_mid = step_go && visible && held_valid_q;
				if (step_go && done) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				load_final = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= DIM_RESET;
			screen_height_q <= DIM_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walker datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q      <= start_x;
			cur_y_q      <= start_y;
			target_x_q   <= end_x;
			target_y_q   <= end_y;
			abs_dx_q     <= init_adx;
			neg_abs_dy_q <= init_nady;
			step_error_q <= init_err;
			x_dec_q      <= !(start_x < end_x);
			y_dec_q      <= !(start_y < end_y);
			color_q      <= line_color;
		end else if (step_go && !done) begin
			step_error_q <= err_next;
			if (x_cond) begin
				cur_x_q <= x_dec_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
			end
			if (y_cond) begin
				cur_y_q <= y_dec_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
			end
		end
		if (step_go && visible) begin
			held_x_q <= cur_x_q[PIX_BITS-1:0];
			held_y_q <= cur_y_q[PIX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (accept || load_final) begin
			held_valid_q <= 1'b0;
		end else if (step_go && visible) begin
			held_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_mid || load_final) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_mid) begin
			pixel_x_q     <= held_x_q;
			pixel_y_q     <= held_y_q;
			pixel_color_q <= color_q;
			pixel_valid_q <= 1'b1;
			last_pixel_q  <= 1'b0;
		end else if (load_final) begin
			pixel_x_q     <= held_valid_q ? held_x_q : '0;
			pixel_y_q     <= held_valid_q ? held_y_q : '0;
			pixel_color_q <= held_valid_q ? color_q : '0;
			pixel_valid_q <= held_valid_q;
			last_pixel_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign pixel_valid = pixel_valid_q;
	assign last_pixel  = last_pixel_q;

endmodule
